/* hdl/distinct_color_palette_collector_unit_assert.svh */
// Assertion macros for the palette collector.
// Expect signals clk and rst_n in the scope of use.
`ifndef DISTINCT_COLOR_PALETTE_COLLECTOR_UNIT_ASSERT_SVH
`define DISTINCT_COLOR_PALETTE_COLLECTOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define DCPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dcpc_pkg.sv */
// Package for the palette collector: item types, sequencer states, luma weights.
// No dependencies.
package dcpc_pkg;

    localparam int PALETTE_SIZE_DEF = 32;
    localparam int COLOR_W          = 24;
    localparam int ENTRY_W          = 5;
    localparam int COUNT_W          = 6;
    localparam int WEIGHT_W         = 16;
    localparam int ACC_W            = 24;

    typedef struct packed {
        logic       start_image;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
        logic               found;
        logic               is_new;
        logic [ENTRY_W-1:0] entry_index;
        logic [COUNT_W-1:0] color_count;
        logic               palette_full;
    } result_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LUMA,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STEP_RED,
        STEP_GREEN,
        STEP_BLUE
    } step_t;

    function automatic logic [WEIGHT_W-1:0] luma_weight(input step_t step);
        logic [WEIGHT_W-1:0] w;
        unique case (step)
            STEP_RED:   w = 16'd19595;
            STEP_GREEN: w = 16'd38470;
            STEP_BLUE:  w = 16'd7471;
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

/* hdl/dcpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/distinct_color_palette_collector_unit.sv */
// Flow: an accepted item runs the red, green and blue luma steps in gray mode (one shared
// multiply-accumulate), then a palette scan on the RAM read port, then the output register.
// One item at a time: not ready again until the result is loaded into the output register.
// Reset clears the entry count, gray mode and the output valid; the palette RAM is not
// cleared, as only entries below the count are ever read.
// Depends on dcpc_pkg, dcpc_ram and the assertion macro header.
`include "distinct_color_palette_collector_unit_assert.svh"

module distinct_color_palette_collector_unit #(
    parameter int PALETTE_SIZE = dcpc_pkg::PALETTE_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dcpc_pkg::pixel_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dcpc_pkg::result_item_t out_data
);

    import dcpc_pkg::*;

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);

    state_t             state_reg, state_next;
    step_t              step_reg, step_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [7:0]         red_reg, red_next;
    logic [7:0]         green_reg, green_next;
    logic [7:0]         blue_reg, blue_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               found_reg, found_next;
    logic               new_reg, new_next;
    logic               full_reg, full_next;
    logic               gray_mode_reg;
    logic               out_valid_reg, out_valid_next;
    result_item_t       out_data_reg, out_data_next;

    logic [7:0]         mac_comp;
    logic [ACC_W-1:0]   mac_prod;
    logic [ACC_W-1:0]   mac_sum;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] ram_rdata;
    logic               ram_we;
    logic               ram_re;
    logic               in_acc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign color     = {red_reg, green_reg, blue_reg};

    always_comb
    begin
        case (step_reg)
            STEP_RED:   mac_comp = red_reg;
            STEP_GREEN: mac_comp = green_reg;
            STEP_BLUE:  mac_comp = blue_reg;
            default:    mac_comp = '0;
        endcase
    end

    assign mac_prod = ACC_W'(luma_weight(step_reg)) * ACC_W'(mac_comp);
    assign mac_sum  = acc_reg + mac_prod;

    dcpc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (color),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            gray_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                gray_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        found_reg    <= found_next;
        new_reg      <= new_next;
        full_reg     <= full_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_idx_next   = hit_idx_reg;
        found_next     = found_reg;
        new_next       = new_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    red_next    = in_data.pixel_red;
                    green_next  = in_data.pixel_green;
                    blue_next   = in_data.pixel_blue;
                    step_next   = STEP_RED;
                    acc_next    = '0;
                    rd_idx_next = '0;
                    if (in_data.start_image)
                    begin
                        count_next = '0;
                    end
                    state_next = gray_mode_reg ? ST_LUMA : ST_SEARCH;
                end
            end

            ST_LUMA:
            begin
                acc_next = mac_sum;
                case (step_reg)
                    STEP_RED:   step_next = STEP_GREEN;
                    STEP_GREEN: step_next = STEP_BLUE;
                    default:
                    begin
                        red_next   = mac_sum[ACC_W-1:ACC_W-8];
                        green_next = mac_sum[ACC_W-1:ACC_W-8];
                        blue_next  = mac_sum[ACC_W-1:ACC_W-8];
                        state_next = ST_SEARCH;
                    end
                endcase
            end

            ST_SEARCH:
            begin
                found_next = 1'b0;
                new_next   = 1'b0;
                full_next  = 1'b0;
                if (count_reg >= CNT_W'(PALETTE_SIZE))
                begin
                    full_next    = 1'b1;
                    hit_idx_next = '0;
                    state_next   = ST_DONE;
                end
                else if (cmp_valid_reg && (ram_rdata == color))
                begin
                    found_next   = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = ST_DONE;
                end
                else if (!cmp_valid_reg && (rd_idx_reg >= count_reg))
                begin
                    ram_we       = 1'b1;
                    new_next     = 1'b1;
                    hit_idx_next = count_reg;
                    count_next   = count_reg + 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    if (rd_idx_reg < count_reg)
                    begin
                        ram_re         = 1'b1;
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = rd_idx_reg;
                        rd_idx_next    = rd_idx_reg + 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.color_red    = red_reg;
                    out_data_next.color_green  = green_reg;
                    out_data_next.color_blue   = blue_reg;
                    out_data_next.found        = found_reg;
                    out_data_next.is_new       = new_reg;
                    out_data_next.entry_index  = ENTRY_W'(hit_idx_reg);
                    out_data_next.color_count  = COUNT_W'(count_reg);
                    out_data_next.palette_full = full_reg;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DCPC_ASSERT_NEXT(a_start_clears, in_acc && in_data.start_image, count_reg == '0,
        "start item did not clear the palette count")
    `DCPC_ASSERT_NEXT(a_insert_counts, ram_we, count_reg == $past(count_reg) + 1'b1,
        "palette insert did not advance the count")
    `DCPC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(PALETTE_SIZE),
        "palette count beyond palette size")
    `DCPC_ASSERT_NOW(a_result_flags, out_valid,
        !(out_data.found && out_data.is_new) &&
        !(out_data.palette_full && (out_data.found || out_data.is_new)),
        "conflicting result flags")

endmodule
